[src/wmd_pkg.sv]
// ----------------------------------------------------------------------------
// wmd_pkg: shared types and constants of the windowed motion detector
// Field widths, register indexes and the layout of one stored pair.
// ----------------------------------------------------------------------------
package wmd_pkg;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W  = 16;
   localparam int DIFF_W    = 16;
   localparam int NOISE_W   = 18;
   localparam int BCOUNT_W  = 5;
   localparam int BSUM_W    = 20;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   // Default number of pairs in the window.
   localparam int DEFAULT_WINDOW_PAIRS = 16;

   // Largest values the result fields can show.
   localparam logic [BCOUNT_W-1:0] COUNT_FIELD_MAX = '1;
   localparam logic [BSUM_W-1:0]   SUM_FIELD_MAX   = '1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_THRESHOLD = 3'd0,
      CSR_BASELINE_COUNT  = 3'd1,
      CSR_BASELINE_X      = 3'd2,
      CSR_BASELINE_Y      = 3'd3,
      CSR_BASELINE_Z      = 3'd4
   } csr_index_type;

   // One stored pair: motion flag and per-axis differences (zero if no motion).
   typedef struct packed {
      logic              motion;
      logic [DIFF_W-1:0] dx;
      logic [DIFF_W-1:0] dy;
      logic [DIFF_W-1:0] dz;
   } pair_type;

   // Absolute difference of two signed samples.
   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                  input logic signed [SAMPLE_W-1:0] b);
      logic signed [SAMPLE_W:0] d;
      logic signed [SAMPLE_W:0] m;
      d = (SAMPLE_W+1)'(a) - (SAMPLE_W+1)'(b);
      m = -d;
      return d[SAMPLE_W] ? m[DIFF_W-1:0] : d[DIFF_W-1:0];
   endfunction

endpackage

[src/windowed_motion_detector.sv]
// ----------------------------------------------------------------------------
// windowed_motion_detector: sliding-window motion detection on 3-axis samples
// Keeps the last WINDOW_PAIRS sample pairs in a ring memory and running sums.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one signed three-axis sample per beat. Each beat
//   yields one rsp beat with the detected flag, the motion pair count and the
//   per-axis difference sums over the motion pairs in the window.
//   A beat moves when valid is high and stall is low.
//   The result is registered in the update stage and then in the output
//   register. Throughput: one sample per cycle while rsp is not stalled.
//   The ring memory is read and written at the same slot in the accept
//   cycle (the old pair comes out while the new one goes in), and the
//   running sums are updated from the update stage, so a single memory
//   port pair and one add/subtract stage set that rate.
//   When rsp is stalled the result holds in its output register, the pending
//   update stage holds behind it, and req_stall rises only once both are full.
//   Reset clears the sample history, the running count and sums, the window
//   fill level and all configuration registers. The ring contents need no
//   clearing: an entry is only read for eviction after it has been written.
//   The csr port is always ready; write it only while no beat is in flight.
// ----------------------------------------------------------------------------
module windowed_motion_detector #(
   parameter int WINDOW_PAIRS = wmd_pkg::DEFAULT_WINDOW_PAIRS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample input.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [wmd_pkg::SAMPLE_W-1:0] req_sample_x,
   input  logic signed [wmd_pkg::SAMPLE_W-1:0] req_sample_y,
   input  logic signed [wmd_pkg::SAMPLE_W-1:0] req_sample_z,
   // Result output.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_detected,
   output logic [wmd_pkg::BCOUNT_W-1:0]        rsp_motion_count,
   output logic [wmd_pkg::BSUM_W-1:0]          rsp_sum_x,
   output logic [wmd_pkg::BSUM_W-1:0]          rsp_sum_y,
   output logic [wmd_pkg::BSUM_W-1:0]          rsp_sum_z,
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wmd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wmd_pkg::CSR_DAT_W-1:0]       csr_data
);
   import wmd_pkg::*;

   localparam int PTR_W  = (WINDOW_PAIRS > 1) ? $clog2(WINDOW_PAIRS) : 1;
   localparam int HELD_W = $clog2(WINDOW_PAIRS + 2);
   localparam int CNT_W  = $clog2(WINDOW_PAIRS + 1);
   localparam int SUM_W  = $clog2(WINDOW_PAIRS * ((1 << DIFF_W) - 1) + 1);
   localparam int CMPC_W = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;
   localparam int CMPS_W = (SUM_W > BSUM_W) ? SUM_W : BSUM_W;
   localparam int STR_W  = DIFF_W + 2;

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW_PAIRS - 1);
   localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(WINDOW_PAIRS + 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_PAIRS);

   // Configuration registers.
   logic [NOISE_W-1:0]  noise_ff;
   logic [BCOUNT_W-1:0] bcount_ff;
   logic [BSUM_W-1:0]   bx_ff, by_ff, bz_ff;

   // History and window state.
   logic signed [SAMPLE_W-1:0] last_x_ff, last_y_ff, last_z_ff;
   logic [PTR_W-1:0]           ptr_ff, ptr_in;
   logic [HELD_W-1:0]          held_ff, held_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [SUM_W-1:0]           sx_ff, sy_ff, sz_ff;
   logic [SUM_W-1:0]           sx_in, sy_in, sz_in;

   // Ring memory and its registered read data.
   pair_type ring_mem [WINDOW_PAIRS];
   pair_type old_ff;

   // Update stage.
   logic     s1_valid_ff, s1_valid_in;
   pair_type s1_new_ff;
   logic     s1_evict_ff;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                det_ff, det_in;
   logic [BCOUNT_W-1:0] cnt_out_ff, cnt_out_in;
   logic [BSUM_W-1:0]   ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;

   logic       accept, s1_fire, has_pair, evict;
   logic [DIFF_W-1:0] dx, dy, dz;
   logic [STR_W-1:0]  strength;
   pair_type   new_pair;

   // Handshake: the update stage drains into the output register.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // New pair from the incoming sample and the previous one, and the next pointer and fill level.
   always_comb begin
      has_pair = (held_ff != '0);
      evict    = (held_ff == HELD_FULL);
      dx       = abs_diff(last_x_ff, req_sample_x);
      dy       = abs_diff(last_y_ff, req_sample_y);
      dz       = abs_diff(last_z_ff, req_sample_z);
      strength = STR_W'(dx) + STR_W'(dy) + STR_W'(dz);
      new_pair.motion = has_pair && (strength > STR_W'(noise_ff));
      new_pair.dx     = new_pair.motion ? dx : '0;
      new_pair.dy     = new_pair.motion ? dy : '0;
      new_pair.dz     = new_pair.motion ? dz : '0;
      ptr_in  = ptr_ff;
      held_in = held_ff;
      if (accept && has_pair) begin
         ptr_in = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
      end
      if (accept && !evict) begin
         held_in = held_ff + HELD_W'(1);
      end
      s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   end

   // Ring read of the leaving pair and write of the entering one.
   always_ff @(posedge clock) begin
      if (accept && has_pair) begin
         old_ff          <= ring_mem[ptr_ff];
         ring_mem[ptr_ff] <= new_pair;
      end
   end

   // Running count and sums after the update, with the baseline check.
   always_comb begin
      logic [CMPS_W-1:0] ex, ey, ez;
      logic [CMPC_W-1:0] ec;
      logic              ev_motion;
      logic [SUM_W-1:0]  odx, ody, odz;
      ev_motion = s1_evict_ff && old_ff.motion;
      odx = s1_evict_ff ? SUM_W'(old_ff.dx) : '0;
      ody = s1_evict_ff ? SUM_W'(old_ff.dy) : '0;
      odz = s1_evict_ff ? SUM_W'(old_ff.dz) : '0;
      count_in = count_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sz_in    = sz_ff;
      if (s1_fire) begin
         count_in = count_ff - CNT_W'(ev_motion) + CNT_W'(s1_new_ff.motion);
         sx_in    = sx_ff - odx + SUM_W'(s1_new_ff.dx);
         sy_in    = sy_ff - ody + SUM_W'(s1_new_ff.dy);
         sz_in    = sz_ff - odz + SUM_W'(s1_new_ff.dz);
      end
      ec = CMPC_W'(count_in);
      ex = CMPS_W'(sx_in);
      ey = CMPS_W'(sy_in);
      ez = CMPS_W'(sz_in);
      // A baseline above the window size asks for a full window.
      det_in = ((ec >= CMPC_W'(bcount_ff)) || (count_in == CNT_FULL))
               && (ex > CMPS_W'(bx_ff)) && (ey > CMPS_W'(by_ff)) && (ez > CMPS_W'(bz_ff));
      cnt_out_in = (ec > CMPC_W'(COUNT_FIELD_MAX)) ? COUNT_FIELD_MAX : ec[BCOUNT_W-1:0];
      ox_in = (ex > CMPS_W'(SUM_FIELD_MAX)) ? SUM_FIELD_MAX : ex[BSUM_W-1:0];
      oy_in = (ey > CMPS_W'(SUM_FIELD_MAX)) ? SUM_FIELD_MAX : ey[BSUM_W-1:0];
      oz_in = (ez > CMPS_W'(SUM_FIELD_MAX)) ? SUM_FIELD_MAX : ez[BSUM_W-1:0];
      rsp_valid_in = s1_fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         held_ff      <= '0;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sz_ff        <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_z_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sz_ff        <= sz_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            last_x_ff <= req_sample_x;
            last_y_ff <= req_sample_y;
            last_z_ff <= req_sample_z;
         end
      end
   end

   // Payload of the update stage and of the output register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_new_ff   <= new_pair;
         s1_evict_ff <= evict;
      end
      if (s1_fire) begin
         det_ff     <= det_in;
         cnt_out_ff <= cnt_out_in;
         ox_ff      <= ox_in;
         oy_ff      <= oy_in;
         oz_ff      <= oz_in;
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff  <= '0;
         bcount_ff <= '0;
         bx_ff     <= '0;
         by_ff     <= '0;
         bz_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NOISE_THRESHOLD: noise_ff  <= csr_data[NOISE_W-1:0];
            CSR_BASELINE_COUNT:  bcount_ff <= csr_data[BCOUNT_W-1:0];
            CSR_BASELINE_X:      bx_ff     <= csr_data;
            CSR_BASELINE_Y:      by_ff     <= csr_data;
            CSR_BASELINE_Z:      bz_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_detected     = det_ff;
   assign rsp_motion_count = cnt_out_ff;
   assign rsp_sum_x        = ox_ff;
   assign rsp_sum_y        = oy_ff;
   assign rsp_sum_z        = oz_ff;

   // The motion count never exceeds the window size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("motion count exceeds window size");

   // With no motion pairs in the window every sum is zero.
   a_sums_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sx_ff == '0 && sy_ff == '0 && sz_ff == '0))
      else $error("nonzero sums without motion pairs");

   // The ring pointer stays at the first slot until a pair exists.
   a_ptr_idle: assert property (@(posedge clock) disable iff (reset)
      (held_ff <= HELD_W'(1)) |-> (ptr_ff == '0))
      else $error("ring pointer moved before the first pair");

   // The first sample after reset never carries a motion pair.
   a_first_sample: assert property (@(posedge clock) disable iff (reset)
      (accept && held_ff == '0) |=> (s1_valid_ff && !s1_new_ff.motion && !s1_evict_ff))
      else $error("first sample produced a pair");

   // A blocked update stage keeps its beat.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> s1_valid_ff)
      else $error("update stage dropped a beat");

endmodule
